### hdl/scba_pkg.sv
// Shared constants, payload types and codes for the size-class block allocator.
package scba_pkg;

   // Sizing of the allocator
   localparam int NUM_CLASSES = 32;
   localparam int STACK_DEPTH = 256;
   localparam int PAGE_BYTES  = 4096;
   localparam int OFFSET_BITS = 32;

   // Derived widths
   localparam int CLS_IDX_W   = $clog2(NUM_CLASSES);
   localparam int IDX_W       = $clog2(STACK_DEPTH);
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int PAGE_W      = $clog2(PAGE_BYTES);
   localparam int STORE_DEPTH = NUM_CLASSES << IDX_W;
   localparam int STORE_AW    = CLS_IDX_W + IDX_W;

   // Length plus header word, and the leading-one search over it
   localparam int LEN_W       = 32;
   localparam int LEN_WORD    = 4;
   localparam int LOG_STEPS   = $clog2(LEN_W);
   localparam int HALF_LEN    = LEN_W / 2;
   localparam int STEP_W      = $clog2(LOG_STEPS);
   localparam int CLS_W       = LOG_STEPS + 1;

   // Configuration port
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 6;

   typedef logic [OFFSET_BITS-1:0] off_type;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_RESIZE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_RANGE   = 2'd1,
      STAT_FULL    = 2'd2,
      STAT_EXHAUST = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_CLASS   = 2'd0,
      CSR_MAX_CLASS   = 2'd1,
      CSR_BREAK_CLASS = 2'd2
   } csr_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOG,
      S_CHECK,
      S_FETCH,
      S_PLAN,
      S_PUSH,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [30:0] payload_length;
      logic [4:0]  block_class;
      logic [31:0] block_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  result_class;
      logic [31:0] result_offset;
      logic        from_free_stack;
   } rsp_type;

endpackage

### hdl/scba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module scba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry and read one entry; the read data is registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/size_class_block_allocator.sv
// Top level of the power-of-two size-class block allocator.
//
// One request is worked at a time; req_ready is high only while the sequencer
// is idle, and a finished item waits in the output register while the next
// request is taken. An allocation runs the leading-one search, the class check,
// the table fetch and the plan; a resize runs the search and check and, if the
// block moves, the fetch, plan and a push; a free checks and pushes; an unused
// opcode goes straight to the result. The class comes from a 5-step leading-one
// search over length + 3, one step a cycle; the free stacks live in a RAM with
// registered read data. Per-class stack counts and bump pointers are registers
// that reset clears; stack entries are not, and only those below the count are used.
module size_class_block_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  scba_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output scba_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [scba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [scba_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import scba_pkg::*;

   // Sequencer and item registers
   state_type             state_ff, state_in;
   logic [1:0]            op_ff, op_in;
   logic [LEN_W-1:0]      val_ff, val_in;
   logic [CLS_W-1:0]      acc_ff, acc_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [CLS_W-1:0]      cls_ff, cls_in;
   logic [4:0]            bc_ff, bc_in;
   logic [31:0]           boff_ff, boff_in;
   logic [COUNT_W-1:0]    cnt_ff, cnt_in;
   off_type               end_ff, end_in;
   rsp_type               res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   // Configuration registers
   logic [4:0]            min_ff;
   logic [5:0]            max_ff;
   logic [5:0]            brk_ff;

   // Per-class stack counts and bump pointers
   logic [COUNT_W-1:0]    count_ff [NUM_CLASSES];
   off_type               bump_ff  [NUM_CLASSES];
   logic                  cnt_we;
   logic [CLS_IDX_W-1:0]  cnt_wi;
   logic [COUNT_W-1:0]    count_in;
   logic                  bump_we;
   off_type               bump_in;

   // Free stack RAM port
   logic                  st_we;
   logic [STORE_AW-1:0]   st_waddr;
   off_type               st_wdata;
   logic [STORE_AW-1:0]   st_raddr;
   off_type               st_rdata;

   // Decision signals
   logic [5:0]            sh_amt;
   logic [LEN_W-1:0]      upper;
   logic                  hit;
   logic [LEN_W-1:0]      val_nx;
   logic [CLS_W-1:0]      acc_nx;
   logic [CLS_W-1:0]      bitlen;
   logic [CLS_W-1:0]      clamped;
   logic                  last_step;
   logic [CLS_IDX_W-1:0]  c_idx;
   logic [CLS_IDX_W-1:0]  b_idx;
   logic [CLS_IDX_W-1:0]  rd_idx;
   logic [COUNT_W-1:0]    count_rd;
   off_type               bump_rd;
   logic                  c_ok;
   logic                  b_ok;
   logic                  b_full;
   logic                  same_cls;
   logic                  partial;
   logic                  take_pop;
   logic [OFFSET_BITS:0]  size;
   logic [OFFSET_BITS:0]  sum;
   logic                  ovf;
   logic                  alloc_err;
   logic                  push_err;
   logic                  rsp_free;

   function automatic logic usable(input logic [CLS_W-1:0] c, input logic [4:0] lo,
                                   input logic [5:0] hi);
      usable = (c >= CLS_W'(lo)) && (CLS_W'(c) < CLS_W'(hi)) && (int'(c) < NUM_CLASSES);
   endfunction

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= 5'd9;
         max_ff <= 6'd31;
         brk_ff <= 6'd12;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_CLASS:   min_ff <= csr_wdata[4:0];
            CSR_MAX_CLASS:   max_ff <= csr_wdata;
            CSR_BREAK_CLASS: brk_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // One step of the leading-one search on length + 3
   always_comb begin
      sh_amt    = 6'(HALF_LEN >> step_ff);
      upper     = val_ff >> sh_amt;
      hit       = (upper != '0);
      val_nx    = hit ? upper : val_ff;
      acc_nx    = acc_ff + (hit ? CLS_W'(sh_amt) : '0);
      bitlen    = acc_nx + CLS_W'(val_nx[0]);
      clamped   = (bitlen < CLS_W'(min_ff)) ? CLS_W'(min_ff) : bitlen;
      last_step = (step_ff == STEP_W'(LOG_STEPS - 1));
   end

   // Class table read port: the new class while fetching, the block's class otherwise
   always_comb begin
      c_idx    = cls_ff[CLS_IDX_W-1:0];
      b_idx    = bc_ff[CLS_IDX_W-1:0];
      rd_idx   = (state_ff == S_FETCH) ? c_idx : b_idx;
      count_rd = count_ff[rd_idx];
      bump_rd  = bump_ff[rd_idx];
      c_ok     = usable(cls_ff, min_ff, max_ff);
      b_ok     = usable(CLS_W'(bc_ff), min_ff, max_ff);
      b_full   = (count_rd >= COUNT_W'(STACK_DEPTH));
      same_cls = (cls_ff == CLS_W'(bc_ff));
   end

   // Plan: bump into a partial page first, then pop, then bump; every bump is checked for overflow
   always_comb begin
      partial   = (CLS_W'(cls_ff) >= CLS_W'(brk_ff)) && (end_ff[PAGE_W-1:0] != '0);
      take_pop  = !partial && (cnt_ff != '0);
      size      = (OFFSET_BITS+1)'(1) << cls_ff;
      sum       = {1'b0, end_ff} + size;
      ovf       = sum[OFFSET_BITS] || (int'(cls_ff) > OFFSET_BITS);
      alloc_err = !take_pop && ovf;
      push_err  = (op_ff == OP_RESIZE) && b_full;
      rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_data.opcode) inside
                  OP_ALLOC, OP_RESIZE: state_in = S_LOG;
                  OP_FREE:             state_in = S_CHECK;
                  default:             state_in = S_DONE;
               endcase
            end
         end
         S_LOG: begin
            if (last_step) state_in = S_CHECK;
         end
         S_CHECK: begin
            unique case (op_ff)
               OP_ALLOC:  state_in = c_ok ? S_FETCH : S_DONE;
               OP_FREE:   state_in = (b_ok && !b_full) ? S_PUSH : S_DONE;
               OP_RESIZE: state_in = (b_ok && !same_cls && c_ok) ? S_FETCH : S_DONE;
               default:   state_in = S_DONE;
            endcase
         end
         S_FETCH: state_in = S_PLAN;
         S_PLAN: begin
            if (alloc_err || push_err || op_ff != OP_RESIZE) state_in = S_DONE;
            else state_in = S_PUSH;
         end
         S_PUSH: state_in = S_DONE;
         S_DONE: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and table updates per state
   always_comb begin
      op_in        = op_ff;
      val_in       = val_ff;
      acc_in       = acc_ff;
      step_in      = step_ff;
      cls_in       = cls_ff;
      bc_in        = bc_ff;
      boff_in      = boff_ff;
      cnt_in       = cnt_ff;
      end_in       = end_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cnt_we       = 1'b0;
      cnt_wi       = c_idx;
      count_in     = cnt_ff - COUNT_W'(1);
      bump_we      = 1'b0;
      bump_in      = sum[OFFSET_BITS-1:0];
      st_we        = 1'b0;
      st_waddr     = {b_idx, count_rd[IDX_W-1:0]};
      st_wdata     = off_type'(boff_ff);
      st_raddr     = {c_idx, IDX_W'(count_rd - COUNT_W'(1))};

      unique case (state_ff)
         S_IDLE: begin
            // Capture the item and seed the search
            if (req_valid) begin
               op_in   = req_data.opcode;
               val_in  = LEN_W'(req_data.payload_length) + LEN_W'(LEN_WORD - 1);
               acc_in  = '0;
               step_in = '0;
               bc_in   = req_data.block_class;
               boff_in = req_data.block_offset;
               res_in  = '0;
            end
         end
         S_LOG: begin
            val_in  = val_nx;
            acc_in  = acc_nx;
            step_in = step_ff + STEP_W'(1);
            if (last_step) cls_in = clamped;
         end
         S_CHECK: begin
            unique case (op_ff)
               OP_ALLOC: begin
                  if (!c_ok) res_in.status = STAT_RANGE;
               end
               OP_FREE: begin
                  if (!b_ok) res_in.status = STAT_RANGE;
                  else if (b_full) res_in.status = STAT_FULL;
               end
               OP_RESIZE: begin
                  // Keep the block when the clamped class is unchanged
                  if (!b_ok) res_in.status = STAT_RANGE;
                  else if (same_cls) begin
                     res_in.result_class  = bc_ff;
                     res_in.result_offset = boff_ff;
                  end else if (!c_ok) res_in.status = STAT_RANGE;
               end
               default: ;
            endcase
         end
         S_FETCH: begin
            cnt_in = count_rd;
            end_in = bump_rd;
         end
         S_PLAN: begin
            if (alloc_err) res_in.status = STAT_EXHAUST;
            else if (push_err) res_in.status = STAT_FULL;
            else begin
               // Commit the allocation half
               res_in.result_class    = cls_ff[4:0];
               res_in.result_offset   = take_pop ? 32'(st_rdata) : 32'(end_ff);
               res_in.from_free_stack = take_pop;
               cnt_we  = take_pop;
               bump_we = !take_pop;
            end
         end
         S_PUSH: begin
            // Push the freed offset on its class stack
            st_we    = 1'b1;
            cnt_we   = 1'b1;
            cnt_wi   = b_idx;
            count_in = count_rd + COUNT_W'(1);
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      val_ff      <= val_in;
      acc_ff      <= acc_in;
      cls_ff      <= cls_in;
      bc_ff       <= bc_in;
      boff_ff     <= boff_in;
      cnt_ff      <= cnt_in;
      end_ff      <= end_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Class tables
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CLASSES; i++) begin
            count_ff[i] <= '0;
            bump_ff[i]  <= '0;
         end
      end else begin
         if (cnt_we) count_ff[cnt_wi] <= count_in;
         if (bump_we) bump_ff[c_idx] <= bump_in;
      end
   end

   // Free stack entries for all classes
   scba_ram #(
      .WIDTH (OFFSET_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
